@@ hdl/cmtd_pkg.sv @@
// Shared types and constants of the cube map texel direction block.
package cmtd_pkg;

    localparam int Q_W        = 16;
    localparam int LANES      = 3;
    localparam int ROOT_BITS  = 16;
    localparam int ROOT_SHIFT = 32;

    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Z = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;

    localparam logic [Q_W-1:0] Q_POS_MAX = 16'h7FFF;
    localparam logic [Q_W-1:0] Q_ONE     = 16'h8000;

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic [LANES-1:0] neg;
    } ctl_t;

endpackage

@@ hdl/cube_map_texel_direction.sv @@
// Top level of the cube map texel direction generator.
// Takes one texel (face, column, row) per clock and returns the unit vector through
// the texel centre as three signed Q1.15 components, rounded to nearest with ties
// away from zero, +1.0 saturating to 32767 and faces 6 and 7 giving zero. The pipeline has
// four front stages (clamp and orientation, squares, sum of squares, seed),
// sixteen stages of the magnitude recurrence that settle one result bit each with
// shifts and adds only, and the output register. Throughput is one texel per clock;
// the whole pipeline holds while a result beat is stalled at the output.
module cube_map_texel_direction #(
    parameter int CUBE_SIZE = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         face,
    input  logic [7:0]         texel_col,
    input  logic [7:0]         texel_row,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] dir_x,
    output logic signed [15:0] dir_y,
    output logic signed [15:0] dir_z
);

    localparam int MW = $clog2(CUBE_SIZE + 1);
    localparam int SW = 2 * MW + 2;
    localparam int RW = 2 * MW + 38;
    localparam int PW = SW + 17;
    localparam int NB = cmtd_pkg::ROOT_BITS;

    logic en;

    cmtd_pkg::ctl_t           ctl_c [NB+1];
    logic [SW-1:0]            s_c   [NB+1];
    logic signed [RW-1:0]     rem_c [NB+1][cmtd_pkg::LANES];
    logic signed [PW-1:0]     p_c   [NB+1][cmtd_pkg::LANES];
    logic [cmtd_pkg::Q_W-1:0] q_c   [NB+1][cmtd_pkg::LANES];

    logic                     out_valid_reg;
    logic [cmtd_pkg::Q_W-1:0] dir_next [cmtd_pkg::LANES];
    logic [cmtd_pkg::Q_W-1:0] dir_reg  [cmtd_pkg::LANES];

    // hold every stage while the result beat waits
    assign in_stall = out_valid_reg & out_stall;
    assign en       = ~in_stall;

    cmtd_setup #(
        .CUBE_SIZE (CUBE_SIZE)
    ) u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .face      (face),
        .texel_col (texel_col),
        .texel_row (texel_row),
        .ctl_out   (ctl_c[0]),
        .s_out     (s_c[0]),
        .rem_out   (rem_c[0]),
        .p_out     (p_c[0])
    );

    always_comb
    begin
        for (int l = 0; l < cmtd_pkg::LANES; l++)
        begin
            q_c[0][l] = '0;
        end
    end

    for (genvar k = 0; k < NB; k++)
    begin : g_root
        cmtd_mag_step #(
            .MW  (MW),
            .BIT (NB - 1 - k)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (ctl_c[k]),
            .s_in    (s_c[k]),
            .rem_in  (rem_c[k]),
            .p_in    (p_c[k]),
            .q_in    (q_c[k]),
            .ctl_out (ctl_c[k+1]),
            .s_out   (s_c[k+1]),
            .rem_out (rem_c[k+1]),
            .p_out   (p_c[k+1]),
            .q_out   (q_c[k+1])
        );
    end

    // apply sign, saturate +1.0, drop invalid faces to zero
    always_comb
    begin
        for (int l = 0; l < cmtd_pkg::LANES; l++)
        begin
            if (ctl_c[NB].zero)
            begin
                dir_next[l] = '0;
            end
            else if (ctl_c[NB].neg[l])
            begin
                dir_next[l] = ~q_c[NB][l] + cmtd_pkg::Q_W'(1);
            end
            else if (q_c[NB][l][cmtd_pkg::Q_W-1])
            begin
                dir_next[l] = cmtd_pkg::Q_POS_MAX;
            end
            else
            begin
                dir_next[l] = q_c[NB][l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ctl_c[NB].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < cmtd_pkg::LANES; l++)
            begin
                dir_reg[l] <= dir_next[l];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign dir_x     = $signed(dir_reg[0]);
    assign dir_y     = $signed(dir_reg[1]);
    assign dir_z     = $signed(dir_reg[2]);

    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_c[NB].valid |-> (q_c[NB][0] <= cmtd_pkg::Q_ONE && q_c[NB][1] <= cmtd_pkg::Q_ONE
                             && q_c[NB][2] <= cmtd_pkg::Q_ONE))
        else $error("magnitude above 1.0 at end of recurrence");

    a_zero_face: assert property (@(posedge clk) disable iff (!rst_n)
        (en && ctl_c[NB].valid && ctl_c[NB].zero)
            |=> (dir_x == 16'sd0 && dir_y == 16'sd0 && dir_z == 16'sd0))
        else $error("invalid face gave a nonzero vector");

    a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (en && ctl_c[NB].valid && !ctl_c[NB].neg[0]) |=> (dir_x != -16'sd32768))
        else $error("positive x component not saturated");

endmodule

@@ hdl/cmtd_setup.sv @@
// Front stages: clamp, face orientation, squares and root recurrence seed.
module cmtd_setup #(
    parameter int CUBE_SIZE = 256,
    localparam int MW  = $clog2(CUBE_SIZE + 1),
    localparam int SQW = 2 * MW,
    localparam int SW  = 2 * MW + 2,
    localparam int RW  = 2 * MW + 38,
    localparam int PW  = SW + 17
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [2:0]              face,
    input  logic [7:0]              texel_col,
    input  logic [7:0]              texel_row,
    output cmtd_pkg::ctl_t          ctl_out,
    output logic [SW-1:0]           s_out,
    output logic signed [RW-1:0]    rem_out [cmtd_pkg::LANES],
    output logic signed [PW-1:0]    p_out   [cmtd_pkg::LANES]
);

    typedef enum logic [1:0] {SRC_A, SRC_B, SRC_N} src_t;

    localparam int XW = MW + 10;
    localparam logic [7:0] CMAX = 8'((CUBE_SIZE - 1 > 255) ? 255 : CUBE_SIZE - 1);
    localparam logic [SQW-1:0] N2 = SQW'(CUBE_SIZE * CUBE_SIZE);

    // stage 1: clamp and orient
    logic [7:0]           col_c;
    logic [7:0]           row_c;
    logic signed [XW-1:0] a_full;
    logic signed [XW-1:0] b_full;
    logic                 a_neg;
    logic                 b_neg;
    src_t                 src_sel  [cmtd_pkg::LANES];
    logic                 flip_sel [cmtd_pkg::LANES];
    cmtd_pkg::ctl_t       ctl1_next;

    cmtd_pkg::ctl_t       ctl1_reg;
    src_t                 src1_reg [cmtd_pkg::LANES];
    logic signed [MW:0]   a1_reg;
    logic signed [MW:0]   b1_reg;

    assign col_c  = (texel_col > CMAX) ? CMAX : texel_col;
    assign row_c  = (texel_row > CMAX) ? CMAX : texel_row;
    assign a_full = $signed({{(XW-9){1'b0}}, col_c, 1'b1}) - $signed(XW'(CUBE_SIZE));
    assign b_full = $signed({{(XW-9){1'b0}}, row_c, 1'b1}) - $signed(XW'(CUBE_SIZE));
    assign a_neg  = a_full[XW-1];
    assign b_neg  = b_full[XW-1];

    always_comb
    begin
        ctl1_next.valid = in_valid;
        ctl1_next.zero  = 1'b0;
        for (int l = 0; l < cmtd_pkg::LANES; l++)
        begin
            src_sel[l]  = SRC_N;
            flip_sel[l] = 1'b0;
        end
        case (face)
            cmtd_pkg::FACE_POS_X:
            begin
                src_sel[0] = SRC_N; flip_sel[0] = 1'b0;
                src_sel[1] = SRC_B; flip_sel[1] = 1'b1;
                src_sel[2] = SRC_A; flip_sel[2] = 1'b1;
            end
            cmtd_pkg::FACE_NEG_X:
            begin
                src_sel[0] = SRC_N; flip_sel[0] = 1'b1;
                src_sel[1] = SRC_B; flip_sel[1] = 1'b1;
                src_sel[2] = SRC_A; flip_sel[2] = 1'b0;
            end
            cmtd_pkg::FACE_POS_Y:
            begin
                src_sel[0] = SRC_A; flip_sel[0] = 1'b0;
                src_sel[1] = SRC_N; flip_sel[1] = 1'b0;
                src_sel[2] = SRC_B; flip_sel[2] = 1'b0;
            end
            cmtd_pkg::FACE_NEG_Y:
            begin
                src_sel[0] = SRC_A; flip_sel[0] = 1'b0;
                src_sel[1] = SRC_N; flip_sel[1] = 1'b1;
                src_sel[2] = SRC_B; flip_sel[2] = 1'b1;
            end
            cmtd_pkg::FACE_POS_Z:
            begin
                src_sel[0] = SRC_A; flip_sel[0] = 1'b0;
                src_sel[1] = SRC_B; flip_sel[1] = 1'b1;
                src_sel[2] = SRC_N; flip_sel[2] = 1'b0;
            end
            cmtd_pkg::FACE_NEG_Z:
            begin
                src_sel[0] = SRC_A; flip_sel[0] = 1'b1;
                src_sel[1] = SRC_B; flip_sel[1] = 1'b1;
                src_sel[2] = SRC_N; flip_sel[2] = 1'b1;
            end
            default:
            begin
                ctl1_next.zero = 1'b1;
            end
        endcase
        for (int l = 0; l < cmtd_pkg::LANES; l++)
        begin
            case (src_sel[l])
                SRC_A:   ctl1_next.neg[l] = flip_sel[l] ^ a_neg;
                SRC_B:   ctl1_next.neg[l] = flip_sel[l] ^ b_neg;
                default: ctl1_next.neg[l] = flip_sel[l];
            endcase
        end
    end

    // stage 2: squares
    logic signed [2*MW+1:0] a_prod;
    logic signed [2*MW+1:0] b_prod;
    cmtd_pkg::ctl_t         ctl2_reg;
    src_t                   src2_reg [cmtd_pkg::LANES];
    logic [SQW-1:0]         a2_reg;
    logic [SQW-1:0]         b2_reg;

    assign a_prod = a1_reg * a1_reg;
    assign b_prod = b1_reg * b1_reg;

    // stage 3: sum of squares, square of each component
    logic [SW-1:0]  s3_next;
    logic [SQW-1:0] csq3_next [cmtd_pkg::LANES];
    cmtd_pkg::ctl_t ctl3_reg;
    logic [SW-1:0]  s3_reg;
    logic [SQW-1:0] csq3_reg [cmtd_pkg::LANES];

    assign s3_next = SW'(a2_reg) + SW'(b2_reg) + SW'(N2);

    always_comb
    begin
        for (int l = 0; l < cmtd_pkg::LANES; l++)
        begin
            case (src2_reg[l])
                SRC_A:   csq3_next[l] = a2_reg;
                SRC_B:   csq3_next[l] = b2_reg;
                default: csq3_next[l] = N2;
            endcase
        end
    end

    // stage 4: seed for q = 0, i.e. T = 2q - 1 = -1
    cmtd_pkg::ctl_t       ctl4_reg;
    logic [SW-1:0]        s4_reg;
    logic signed [RW-1:0] rem4_next [cmtd_pkg::LANES];
    logic signed [RW-1:0] rem4_reg  [cmtd_pkg::LANES];
    logic signed [PW-1:0] p4_next;
    logic signed [PW-1:0] p4_reg;

    always_comb
    begin
        for (int l = 0; l < cmtd_pkg::LANES; l++)
        begin
            rem4_next[l] = $signed({{(RW-SQW-cmtd_pkg::ROOT_SHIFT){1'b0}}, csq3_reg[l],
                                    {cmtd_pkg::ROOT_SHIFT{1'b0}}})
                         - $signed(RW'(s3_reg));
        end
    end

    assign p4_next = -$signed(PW'(s3_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= a_full[MW:0];
            b1_reg <= b_full[MW:0];
            a2_reg <= a_prod[SQW-1:0];
            b2_reg <= b_prod[SQW-1:0];
            s3_reg <= s3_next;
            s4_reg <= s3_reg;
            p4_reg <= p4_next;
            for (int l = 0; l < cmtd_pkg::LANES; l++)
            begin
                src1_reg[l] <= src_sel[l];
                src2_reg[l] <= src1_reg[l];
                csq3_reg[l] <= csq3_next[l];
                rem4_reg[l] <= rem4_next[l];
            end
        end
    end

    assign ctl_out = ctl4_reg;
    assign s_out   = s4_reg;

    always_comb
    begin
        for (int l = 0; l < cmtd_pkg::LANES; l++)
        begin
            rem_out[l] = rem4_reg[l];
            p_out[l]   = p4_reg;
        end
    end

endmodule

@@ hdl/cmtd_mag_step.sv @@
// One bit of the rounded magnitude recurrence, all three lanes.
module cmtd_mag_step #(
    parameter int MW  = 9,
    parameter int BIT = 15,
    localparam int SW = 2 * MW + 2,
    localparam int RW = 2 * MW + 38,
    localparam int PW = SW + 17
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  cmtd_pkg::ctl_t               ctl_in,
    input  logic [SW-1:0]                s_in,
    input  logic signed [RW-1:0]         rem_in [cmtd_pkg::LANES],
    input  logic signed [PW-1:0]         p_in   [cmtd_pkg::LANES],
    input  logic [cmtd_pkg::Q_W-1:0]     q_in   [cmtd_pkg::LANES],
    output cmtd_pkg::ctl_t               ctl_out,
    output logic [SW-1:0]                s_out,
    output logic signed [RW-1:0]         rem_out [cmtd_pkg::LANES],
    output logic signed [PW-1:0]         p_out   [cmtd_pkg::LANES],
    output logic [cmtd_pkg::Q_W-1:0]     q_out   [cmtd_pkg::LANES]
);

    // rem = c^2 * 2^32 - T^2 * s and p = T * s, with T = 2q - 1.
    // Setting bit BIT of q adds 2^(BIT+1) to T.
    logic signed [RW-1:0] s_sq_term;
    logic signed [PW-1:0] s_p_term;
    logic signed [RW-1:0] cand      [cmtd_pkg::LANES];
    logic signed [RW-1:0] rem_next  [cmtd_pkg::LANES];
    logic signed [PW-1:0] p_next    [cmtd_pkg::LANES];
    logic [cmtd_pkg::Q_W-1:0] q_next [cmtd_pkg::LANES];

    cmtd_pkg::ctl_t           ctl_reg;
    logic [SW-1:0]            s_reg;
    logic signed [RW-1:0]     rem_reg [cmtd_pkg::LANES];
    logic signed [PW-1:0]     p_reg   [cmtd_pkg::LANES];
    logic [cmtd_pkg::Q_W-1:0] q_reg   [cmtd_pkg::LANES];

    assign s_sq_term = $signed(RW'(s_in) << (2 * BIT + 2));
    assign s_p_term  = $signed(PW'(s_in) << (BIT + 1));

    always_comb
    begin
        for (int l = 0; l < cmtd_pkg::LANES; l++)
        begin
            cand[l] = rem_in[l] - (RW'(p_in[l]) <<< (BIT + 2)) - s_sq_term;
            if (!cand[l][RW-1])
            begin
                rem_next[l] = cand[l];
                p_next[l]   = p_in[l] + s_p_term;
                q_next[l]   = q_in[l] | (cmtd_pkg::Q_W'(1) << BIT);
            end
            else
            begin
                rem_next[l] = rem_in[l];
                p_next[l]   = p_in[l];
                q_next[l]   = q_in[l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= s_in;
            for (int l = 0; l < cmtd_pkg::LANES; l++)
            begin
                rem_reg[l] <= rem_next[l];
                p_reg[l]   <= p_next[l];
                q_reg[l]   <= q_next[l];
            end
        end
    end

    assign ctl_out = ctl_reg;
    assign s_out   = s_reg;

    always_comb
    begin
        for (int l = 0; l < cmtd_pkg::LANES; l++)
        begin
            rem_out[l] = rem_reg[l];
            p_out[l]   = p_reg[l];
            q_out[l]   = q_reg[l];
        end
    end

endmodule

@@ sim/tb_top.sv @@
// Testbench for the cube map texel direction block: directed and random texels, scoreboard.
`timescale 1ns / 100ps

module tb_top;

    localparam int           EDGE_N      = 256;
    localparam int           DRAIN_CYCLES = 40;
    localparam logic [2:0]   FACE_VOID_A = 3'd6;
    localparam logic [2:0]   FACE_VOID_B = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         face;
    logic [7:0]         texel_col;
    logic [7:0]         texel_row;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;

    bit src_gaps;
    bit sink_gaps;

    class texel_dir_board;
        typedef struct {
            logic [2:0]         face;
            logic [7:0]         col;
            logic [7:0]         row;
            logic signed [15:0] x;
            logic signed [15:0] y;
            logic signed [15:0] z;
        } unit_dir_t;

        unit_dir_t dir_queue[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return dir_queue.size();
        endfunction

        task report_miss(input string msg);
            if (errors < 100)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // Q1.15 component c / sqrt(s), rounded half away from zero, +1.0 held at max.
        function logic [15:0] q15_component(input longint c, input longint unsigned s);
            longint unsigned mag;
            longint unsigned rhs;
            longint unsigned t;
            int unsigned     lo;
            int unsigned     hi;
            int unsigned     mid;
            logic [15:0]     v;
            mag = (c < 0) ? -c : c;
            rhs = (mag * mag) << 32;
            lo = 0;
            hi = 32768;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) >> 1;
                t = mid;
                t = 2 * t - 1;
                if (t * t * s <= rhs)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            v = lo[15:0];
            if (c < 0)
                return -v;
            if (lo > 32767)
                return cmtd_pkg::Q_POS_MAX;
            return v;
        endfunction

        function void note_texel(input logic [2:0] f, input logic [7:0] c, input logic [7:0] r);
            unit_dir_t       d;
            longint          col;
            longint          row;
            longint          a;
            longint          b;
            longint          n;
            longint          vx;
            longint          vy;
            longint          vz;
            longint unsigned s;
            bit              void_face;
            n = EDGE_N;
            col = c;
            row = r;
            // clamp out-of-range coordinates to the last texel
            if (col > n - 1)
                col = n - 1;
            if (row > n - 1)
                row = n - 1;
            a = 2 * col + 1 - n;
            b = 2 * row + 1 - n;
            void_face = 1'b0;
            vx = 0;
            vy = 0;
            vz = 0;
            case (f)
                cmtd_pkg::FACE_POS_X:
                begin
                    vx = n;  vy = -b; vz = -a;
                end
                cmtd_pkg::FACE_NEG_X:
                begin
                    vx = -n; vy = -b; vz = a;
                end
                cmtd_pkg::FACE_POS_Y:
                begin
                    vx = a;  vy = n;  vz = b;
                end
                cmtd_pkg::FACE_NEG_Y:
                begin
                    vx = a;  vy = -n; vz = -b;
                end
                cmtd_pkg::FACE_POS_Z:
                begin
                    vx = a;  vy = -b; vz = n;
                end
                cmtd_pkg::FACE_NEG_Z:
                begin
                    vx = -a; vy = -b; vz = -n;
                end
                default:    void_face = 1'b1;
            endcase
            d.face = f;
            d.col  = c;
            d.row  = r;
            if (void_face)
            begin
                d.x = '0;
                d.y = '0;
                d.z = '0;
            end
            else
            begin
                s = a * a + b * b + n * n;
                d.x = q15_component(vx, s);
                d.y = q15_component(vy, s);
                d.z = q15_component(vz, s);
            end
            dir_queue.push_back(d);
        endfunction

        task check_dir(input logic signed [15:0] x, input logic signed [15:0] y,
                       input logic signed [15:0] z);
            unit_dir_t d;
            string     tag;
            if (dir_queue.size() == 0)
            begin
                report_miss($sformatf("result beat with nothing expected (%0d %0d %0d)",
                                      x, y, z));
                return;
            end
            d = dir_queue.pop_front();
            tag = $sformatf("face %0d col %0d row %0d", d.face, d.col, d.row);
            if (x !== d.x)
                report_miss($sformatf("%s dir_x got %0d want %0d", tag, x, d.x));
            if (y !== d.y)
                report_miss($sformatf("%s dir_y got %0d want %0d", tag, y, d.y));
            if (z !== d.z)
                report_miss($sformatf("%s dir_z got %0d want %0d", tag, z, d.z));
        endtask
    endclass

    texel_dir_board board;

    cube_map_texel_direction #(
        .CUBE_SIZE (EDGE_N)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .face      (face),
        .texel_col (texel_col),
        .texel_row (texel_row),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: check each accepted beat, then pick the next stall.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_dir(dir_x, dir_y, dir_z);
        out_stall <= sink_gaps && ($urandom_range(99) < 30);
    end

    // Called just after a rising edge; returns just after the edge that took the beat.
    task automatic send_texel(input logic [2:0] f, input logic [7:0] c, input logic [7:0] r);
        while (src_gaps && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        face      <= f;
        texel_col <= c;
        texel_row <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_texel(f, c, r);
    endtask

    function automatic logic [7:0] pick_coord();
        case ($urandom_range(15))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd127;
            3:       return 8'd128;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_directed();
        logic [2:0] f;
        for (int i = cmtd_pkg::FACE_POS_X; i <= cmtd_pkg::FACE_NEG_Z; i++)
        begin
            f = 3'(i);
            send_texel(f, 8'd0, 8'd0);
            send_texel(f, 8'd255, 8'd255);
        end
        send_texel(cmtd_pkg::FACE_POS_X, 8'd0, 8'd255);
        send_texel(cmtd_pkg::FACE_POS_X, 8'd255, 8'd0);
        send_texel(cmtd_pkg::FACE_POS_Z, 8'd127, 8'd127);
        send_texel(cmtd_pkg::FACE_POS_Z, 8'd128, 8'd128);
        send_texel(cmtd_pkg::FACE_NEG_Y, 8'd127, 8'd128);
        send_texel(FACE_VOID_A, 8'd255, 8'd0);
        send_texel(FACE_VOID_A, 8'd0, 8'd255);
        send_texel(FACE_VOID_B, 8'd255, 8'd255);
        send_texel(FACE_VOID_B, 8'd0, 8'd0);
    endtask

    task automatic send_random(input int count);
        logic [2:0] f;
        logic [7:0] c;
        logic [7:0] r;
        repeat (count)
        begin
            if ($urandom_range(9) == 0)
                f = $urandom_range(1) ? FACE_VOID_B : FACE_VOID_A;
            else
                f = 3'($urandom_range(cmtd_pkg::FACE_NEG_Z, cmtd_pkg::FACE_POS_X));
            c = pick_coord();
            r = pick_coord();
            send_texel(f, c, r);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        face      = '0;
        texel_col = '0;
        texel_row = '0;
        out_stall = 1'b0;
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        send_random(700);

        // hold the sender until the pipeline has drained
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        @(posedge clk);

        // back-to-back stretch at full rate
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        send_random(500);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        send_random(700);

        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("timeout with %0d results outstanding", board.pending());
        $display("FAIL");
        $finish;
    end

endmodule
